/* rtl/particle_step_with_box_collision_defines.svh */
// Assertion macros used by the top-level RTL file.
`ifndef PARTICLE_STEP_WITH_BOX_COLLISION_DEFINES_SVH
`define PARTICLE_STEP_WITH_BOX_COLLISION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/psb_pkg.sv */
package psb_pkg;

  // Fixed-point layout and limits
  localparam int POS_FRAC_BITS = 4;
  localparam int MAX_WALLS_DEF = 16;
  localparam int DIV_SHIFT     = 8 - POS_FRAC_BITS;
  localparam int NUM_W         = 29;
  localparam int BOX_W         = 21;
  localparam logic [12:0] DT_MAX = 13'd6554;

  // Register reset values
  localparam logic [15:0] MASS_RST     = 16'd2560;
  localparam logic [13:0] RADIUS_RST   = 14'd320;
  localparam logic [15:0] WORLD_RST    = 16'd32000;
  localparam logic [15:0] FRICTION_RST = 16'd62915;
  localparam logic [15:0] BOUNCE_RST   = 16'd32768;

  typedef enum logic [1:0] {
    CMD_STEP  = 2'd0,
    CMD_WALL  = 2'd1,
    CMD_PLACE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_MASS       = 3'd0,
    CFG_RADIUS     = 3'd1,
    CFG_LIMIT_X    = 3'd2,
    CFG_LIMIT_Y    = 3'd3,
    CFG_FRICTION   = 3'd4,
    CFG_BOUNCE     = 3'd5,
    CFG_WALL_COUNT = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FMUL, ST_DIV_GO, ST_DIV_WAIT, ST_ACC, ST_FRIC, ST_FRIC_APPLY,
    ST_MVX, ST_MVX_ADD, ST_SCAN_X, ST_BNC_X, ST_MVY, ST_MVY_ADD, ST_SCAN_Y,
    ST_BNC_Y, ST_DONE
  } state_t;

  // Normalized wall rectangle
  typedef struct packed {
    logic signed [16:0] left;
    logic signed [16:0] right;
    logic signed [16:0] top;
    logic signed [16:0] bottom;
  } wall_t;

  // Particle box under test
  typedef struct packed {
    logic signed [BOX_W-1:0] left;
    logic signed [BOX_W-1:0] right;
    logic signed [BOX_W-1:0] top;
    logic signed [BOX_W-1:0] bottom;
  } box_t;

  function automatic logic signed [18:0] sat_vel(input logic signed [30:0] v);
    if (v > 31'sd262143) return 19'sd262143;
    if (v < -31'sd262144) return -19'sd262144;
    return v[18:0];
  endfunction

  function automatic logic signed [18:0] apply_sign(input logic [18:0] mag, input logic neg);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

/* rtl/psb_div.sv */
// Restoring divider, one quotient bit per cycle
module psb_div #(
  parameter int NW = 29,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [NW-1:0] q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  // trial subtract of the next numerator bit
  always_comb begin
    trial = {rem, q[NW-1]};
    diff  = trial - {1'b0, den};
    ge    = !diff[DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
    end else if (cnt != '0) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      q   <= {q[NW-2:0], ge};
    end
  end

  assign busy = (cnt != '0);
  assign quo  = q;

endmodule

/* rtl/psb_wall_scan.sv */
// Wall table and sequential overlap scan, one entry per cycle
module psb_wall_scan #(
  parameter int MAX_WALLS = psb_pkg::MAX_WALLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [(MAX_WALLS > 1 ? $clog2(MAX_WALLS) : 1)-1:0] wr_idx,
  input  psb_pkg::wall_t       wr_data,
  input  logic                 start,
  input  logic [$clog2(MAX_WALLS + 1)-1:0] count,
  input  psb_pkg::box_t        box,
  output logic                 busy,
  output logic                 hit
);

  localparam int IW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam int BW = psb_pkg::BOX_W;

  psb_pkg::wall_t mem [MAX_WALLS];
  psb_pkg::wall_t rd_data;
  logic [CW-1:0]  addr;
  logic           issuing;
  logic           rd_valid;
  logic           overlap;

  // table write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // table read port, registered
  always_ff @(posedge clk) begin
    if (issuing) begin
      rd_data <= mem[addr[IW-1:0]];
    end
  end

  // strict overlap of box and wall on both axes
  always_comb begin
    overlap = (box.left < box.right) && (box.top < box.bottom) &&
              (rd_data.left < rd_data.right) && (rd_data.top < rd_data.bottom) &&
              (box.left < BW'(rd_data.right)) && (BW'(rd_data.left) < box.right) &&
              (box.top < BW'(rd_data.bottom)) && (BW'(rd_data.top) < box.bottom);
  end

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing  <= 1'b0;
      rd_valid <= 1'b0;
      addr     <= '0;
      hit      <= 1'b0;
    end else if (start) begin
      issuing  <= (count != '0);
      rd_valid <= 1'b0;
      addr     <= '0;
      hit      <= 1'b0;
    end else begin
      rd_valid <= issuing;
      if (issuing) begin
        addr <= addr + 1'b1;
        if (CW'(addr + 1'b1) == count) begin
          issuing <= 1'b0;
        end
      end
      if (rd_valid && overlap) begin
        hit <= 1'b1;
      end
    end
  end

  assign busy = issuing | rd_valid;

endmodule

/* rtl/particle_step_with_box_collision.sv */
// One particle in a box world with up to MAX_WALLS rectangular walls. Every input
// beat gives exactly one result beat. A write-wall, reset-particle or unknown command
// goes straight to the done state after acceptance and has its result registered
// there once the result register is free. A step scales both forces by dt, runs
// both force divisions in parallel through bit-serial dividers, applies friction,
// then moves each axis in turn, scanning the wall memory one entry per cycle, and
// bounces an axis that is blocked. One item is in work at a time; the result
// register lets the next beat enter while a result still waits, and a stalled result
// holds the item in its last state. Config is always ready.
`include "particle_step_with_box_collision_defines.svh"

module particle_step_with_box_collision #(
  parameter int MAX_WALLS = psb_pkg::MAX_WALLS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // config write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  // input beat
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cmd,
  input  logic signed [16:0]  force_x,
  input  logic signed [16:0]  force_y,
  input  logic [15:0]         dt,
  input  logic [3:0]          wall_index,
  input  logic signed [16:0]  wall_left,
  input  logic signed [16:0]  wall_top,
  input  logic signed [16:0]  wall_right,
  input  logic signed [16:0]  wall_bottom,
  // result beat
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [18:0]  vel_x,
  output logic signed [18:0]  vel_y,
  output logic                blocked_x,
  output logic                blocked_y
);

  localparam int IW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int CW = $clog2(MAX_WALLS + 1);
  localparam int BW = psb_pkg::BOX_W;
  localparam int NW = psb_pkg::NUM_W;

  psb_pkg::state_t state, state_next;

  // config registers
  logic [15:0] mass, limit_x, limit_y, friction, bounce;
  logic [13:0] radius;
  logic [4:0]  wall_count;

  // particle state
  logic signed [16:0] particle_x, particle_y;
  logic signed [18:0] speed_x, speed_y;

  // per-item registers
  logic signed [16:0] fx, fy;
  logic [12:0]        dt_sat;
  logic               bx, by;
  logic signed [19:0] cand_x, cand_y;
  logic [34:0]        prod_x, prod_y;

  logic        accept;
  logic        out_free;
  logic        div_start, scan_start;
  logic        div_busy_x, div_busy_y;
  logic [NW-1:0] quo_x, quo_y;
  logic [15:0] den;
  logic [18:0] mul_a_x, mul_a_y;
  logic [15:0] mul_b_x, mul_b_y;
  logic        scan_busy, scan_hit;
  logic        world_hit_x, world_hit_y;
  logic        blocked_now;
  logic [CW-1:0] count_sat;
  logic [IW-1:0] wr_idx;
  logic [12:0]   idx_rem;
  psb_pkg::wall_t wr_wall;
  psb_pkg::box_t  box;
  logic signed [BW-1:0] rad_s;
  logic signed [BW-1:0] cx_s, cy_s, px_s, py_s;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != psb_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mass       <= psb_pkg::MASS_RST;
      radius     <= psb_pkg::RADIUS_RST;
      limit_x    <= psb_pkg::WORLD_RST;
      limit_y    <= psb_pkg::WORLD_RST;
      friction   <= psb_pkg::FRICTION_RST;
      bounce     <= psb_pkg::BOUNCE_RST;
      wall_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psb_pkg::CFG_MASS:       mass       <= cfg_data;
        psb_pkg::CFG_RADIUS:     radius     <= cfg_data[13:0];
        psb_pkg::CFG_LIMIT_X:    limit_x    <= cfg_data;
        psb_pkg::CFG_LIMIT_Y:    limit_y    <= cfg_data;
        psb_pkg::CFG_FRICTION:   friction   <= cfg_data;
        psb_pkg::CFG_BOUNCE:     bounce     <= cfg_data;
        psb_pkg::CFG_WALL_COUNT: wall_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // wall write: table index modulo depth, edges normalized
  always_comb begin
    idx_rem = {9'd0, wall_index};
    for (int j = 3; j >= 0; j--) begin
      if (idx_rem >= 13'(MAX_WALLS << j)) begin
        idx_rem = idx_rem - 13'(MAX_WALLS << j);
      end
    end
    wr_idx         = idx_rem[IW-1:0];
    wr_wall.left   = (wall_left < wall_right) ? wall_left : wall_right;
    wr_wall.right  = (wall_left < wall_right) ? wall_right : wall_left;
    wr_wall.top    = (wall_top < wall_bottom) ? wall_top : wall_bottom;
    wr_wall.bottom = (wall_top < wall_bottom) ? wall_bottom : wall_top;
    count_sat = (32'(wall_count) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(wall_count);
  end

  // box under test and world limits
  always_comb begin
    rad_s = BW'($signed({1'b0, radius}));
    cx_s  = BW'(cand_x);
    cy_s  = BW'(cand_y);
    px_s  = BW'(particle_x);
    py_s  = BW'(particle_y);
    if (state == psb_pkg::ST_SCAN_Y) begin
      box.left   = px_s - rad_s;
      box.right  = px_s + rad_s;
      box.top    = cy_s - rad_s;
      box.bottom = cy_s + rad_s;
    end else begin
      box.left   = cx_s - rad_s;
      box.right  = cx_s + rad_s;
      box.top    = py_s - rad_s;
      box.bottom = py_s + rad_s;
    end
    world_hit_x = (cx_s - rad_s < 0) || (cx_s + rad_s > BW'($signed({1'b0, limit_x})));
    world_hit_y = (cy_s - rad_s < 0) || (cy_s + rad_s > BW'($signed({1'b0, limit_y})));
    blocked_now = scan_hit ||
                  ((state == psb_pkg::ST_SCAN_Y) ? world_hit_y : world_hit_x);
  end

  // multiplier operands per state
  always_comb begin
    mul_a_x = (state == psb_pkg::ST_FMUL) ? 19'(fx < 0 ? -fx : fx)
                                          : 19'(speed_x < 0 ? -speed_x : speed_x);
    mul_a_y = (state == psb_pkg::ST_FMUL) ? 19'(fy < 0 ? -fy : fy)
                                          : 19'(speed_y < 0 ? -speed_y : speed_y);
    if (state == psb_pkg::ST_FMUL || state == psb_pkg::ST_MVX) begin
      mul_b_x = {3'd0, dt_sat};
    end else if (state == psb_pkg::ST_FRIC) begin
      mul_b_x = friction;
    end else begin
      mul_b_x = bounce;
    end
    if (state == psb_pkg::ST_FMUL || state == psb_pkg::ST_MVY) begin
      mul_b_y = {3'd0, dt_sat};
    end else if (state == psb_pkg::ST_FRIC) begin
      mul_b_y = friction;
    end else begin
      mul_b_y = bounce;
    end
    den = (mass == '0) ? 16'd1 : mass;
  end

  // registered products, one lane per axis
  always_ff @(posedge clk) begin
    prod_x <= mul_a_x * mul_b_x;
    prod_y <= mul_a_y * mul_b_y;
  end

  psb_div #(.NW(NW), .DW(16)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NW'(prod_x >> psb_pkg::DIV_SHIFT)), .den(den),
    .busy(div_busy_x), .quo(quo_x)
  );

  psb_div #(.NW(NW), .DW(16)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start),
    .num(NW'(prod_y >> psb_pkg::DIV_SHIFT)), .den(den),
    .busy(div_busy_y), .quo(quo_y)
  );

  psb_wall_scan #(.MAX_WALLS(MAX_WALLS)) u_scan (
    .clk(clk), .rst(rst),
    .wr_en(accept && cmd == psb_pkg::CMD_WALL), .wr_idx(wr_idx), .wr_data(wr_wall),
    .start(scan_start), .count(count_sat), .box(box),
    .busy(scan_busy), .hit(scan_hit)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    scan_start = 1'b0;
    unique case (state)
      psb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (cmd == psb_pkg::CMD_STEP) ? psb_pkg::ST_FMUL : psb_pkg::ST_DONE;
        end
      end
      psb_pkg::ST_FMUL:       state_next = psb_pkg::ST_DIV_GO;
      psb_pkg::ST_DIV_GO: begin
        div_start  = 1'b1;
        state_next = psb_pkg::ST_DIV_WAIT;
      end
      psb_pkg::ST_DIV_WAIT: begin
        if (!div_busy_x && !div_busy_y) state_next = psb_pkg::ST_ACC;
      end
      psb_pkg::ST_ACC:        state_next = psb_pkg::ST_FRIC;
      psb_pkg::ST_FRIC:       state_next = psb_pkg::ST_FRIC_APPLY;
      psb_pkg::ST_FRIC_APPLY: state_next = psb_pkg::ST_MVX;
      psb_pkg::ST_MVX:        state_next = psb_pkg::ST_MVX_ADD;
      psb_pkg::ST_MVX_ADD: begin
        scan_start = 1'b1;
        state_next = psb_pkg::ST_SCAN_X;
      end
      psb_pkg::ST_SCAN_X: begin
        if (!scan_busy) state_next = blocked_now ? psb_pkg::ST_BNC_X : psb_pkg::ST_MVY;
      end
      psb_pkg::ST_BNC_X:      state_next = psb_pkg::ST_MVY;
      psb_pkg::ST_MVY:        state_next = psb_pkg::ST_MVY_ADD;
      psb_pkg::ST_MVY_ADD: begin
        scan_start = 1'b1;
        state_next = psb_pkg::ST_SCAN_Y;
      end
      psb_pkg::ST_SCAN_Y: begin
        if (!scan_busy) state_next = blocked_now ? psb_pkg::ST_BNC_Y : psb_pkg::ST_DONE;
      end
      psb_pkg::ST_BNC_Y:      state_next = psb_pkg::ST_DONE;
      psb_pkg::ST_DONE: begin
        if (out_free) state_next = psb_pkg::ST_IDLE;
      end
      default:                state_next = psb_pkg::ST_IDLE;
    endcase
  end

  // item fields
  always_ff @(posedge clk) begin
    if (accept) begin
      fx     <= force_x;
      fy     <= force_y;
      dt_sat <= (dt > 16'(psb_pkg::DT_MAX)) ? psb_pkg::DT_MAX : dt[12:0];
    end
    if (state == psb_pkg::ST_MVX_ADD) begin
      cand_x <= 20'(particle_x) + 20'(psb_pkg::apply_sign(prod_x[34:16], speed_x < 0));
    end
    if (state == psb_pkg::ST_MVY_ADD) begin
      cand_y <= 20'(particle_y) + 20'(psb_pkg::apply_sign(prod_y[34:16], speed_y < 0));
    end
  end

  // particle state update
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_x <= 17'(psb_pkg::WORLD_RST >> 1);
      particle_y <= 17'(psb_pkg::WORLD_RST >> 1);
      speed_x    <= '0;
      speed_y    <= '0;
      bx         <= 1'b0;
      by         <= 1'b0;
    end else begin
      if (accept) begin
        bx <= 1'b0;
        by <= 1'b0;
        if (cmd == psb_pkg::CMD_PLACE) begin
          particle_x <= 17'(limit_x >> 1);
          particle_y <= 17'(limit_y >> 1);
          speed_x    <= '0;
          speed_y    <= '0;
        end
      end
      unique case (state)
        psb_pkg::ST_ACC: begin
          speed_x <= psb_pkg::sat_vel(31'(speed_x) +
                     (fx < 0 ? -$signed(31'(quo_x)) : $signed(31'(quo_x))));
          speed_y <= psb_pkg::sat_vel(31'(speed_y) +
                     (fy < 0 ? -$signed(31'(quo_y)) : $signed(31'(quo_y))));
        end
        psb_pkg::ST_FRIC_APPLY: begin
          speed_x <= psb_pkg::apply_sign(prod_x[34:16], speed_x < 0);
          speed_y <= psb_pkg::apply_sign(prod_y[34:16], speed_y < 0);
        end
        psb_pkg::ST_SCAN_X: begin
          if (!scan_busy) begin
            if (blocked_now) bx <= 1'b1;
            else particle_x <= cand_x[16:0];
          end
        end
        psb_pkg::ST_BNC_X: speed_x <= -psb_pkg::apply_sign(prod_x[34:16], speed_x < 0);
        psb_pkg::ST_SCAN_Y: begin
          if (!scan_busy) begin
            if (blocked_now) by <= 1'b1;
            else particle_y <= cand_y[16:0];
          end
        end
        psb_pkg::ST_BNC_Y: speed_y <= -psb_pkg::apply_sign(prod_y[34:16], speed_y < 0);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == psb_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == psb_pkg::ST_DONE && out_free) begin
      pos_x     <= particle_x;
      pos_y     <= particle_y;
      vel_x     <= speed_x;
      vel_y     <= speed_y;
      blocked_x <= bx;
      blocked_y <= by;
    end
  end

  `PSB_ASSERT_NEXT(a_busy_after_accept, accept, state != psb_pkg::ST_IDLE, "idle after accept")
  `PSB_ASSERT_NOW(a_div_only_in_wait, div_busy_x || div_busy_y, state == psb_pkg::ST_DIV_WAIT, "divider runs outside wait")
  `PSB_ASSERT_NOW(a_scan_idle_when_idle, state == psb_pkg::ST_IDLE, !scan_busy, "scan runs while idle")
  `PSB_ASSERT_NEXT(a_blocked_x_holds, state == psb_pkg::ST_SCAN_X && !scan_busy && blocked_now, particle_x == $past(particle_x), "blocked x move not reverted")

endmodule

/* tb/testbench.sv */
module testbench;

  // One input beat
  typedef struct {
    logic [1:0]         op;
    logic signed [16:0] fx;
    logic signed [16:0] fy;
    logic [15:0]        dt;
    logic [3:0]         idx;
    logic signed [16:0] wl;
    logic signed [16:0] wt;
    logic signed [16:0] wr;
    logic signed [16:0] wb;
  } beat_t;

  // One result beat
  typedef struct {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [18:0] vx;
    logic signed [18:0] vy;
    logic               bx;
    logic               by;
  } state_beat_t;

  // Particle predictor plus expected-state queue
  class particle_scoreboard;
    longint       mass, radius, width, height, friction, bounce, nwalls;
    longint       px, py, vx, vy;
    longint       wx0[16], wx1[16], wy0[16], wy1[16];
    state_beat_t  pending_q[$];
    int           errors;

    function new();
      mass = psb_pkg::MASS_RST; radius = psb_pkg::RADIUS_RST;
      width = psb_pkg::WORLD_RST; height = psb_pkg::WORLD_RST;
      friction = psb_pkg::FRICTION_RST; bounce = psb_pkg::BOUNCE_RST; nwalls = 0;
      errors = 0;
      center();
    endfunction

    function void center();
      px = width >> 1; py = height >> 1; vx = 0; vy = 0;
    endfunction

    function void set_reg(psb_pkg::cfg_idx_t i, logic [15:0] d);
      case (i)
        psb_pkg::CFG_MASS:       mass = d;
        psb_pkg::CFG_RADIUS:     radius = d[13:0];
        psb_pkg::CFG_LIMIT_X:    width = d;
        psb_pkg::CFG_LIMIT_Y:    height = d;
        psb_pkg::CFG_FRICTION:   friction = d;
        psb_pkg::CFG_BOUNCE:     bounce = d;
        psb_pkg::CFG_WALL_COUNT: nwalls = d[4:0];
        default: ;
      endcase
    endfunction

    function longint clamp_vel(longint v);
      if (v > 262143) return 262143;
      if (v < -262144) return -262144;
      return v;
    endfunction

    // v * f / 2^16, truncated by magnitude
    function longint mul_q16(longint v, longint f);
      longint m;
      m = v < 0 ? -v : v;
      m = (m * f) >> 16;
      return v < 0 ? -m : m;
    endfunction

    function longint force_dv(longint f, longint t);
      longint m, mag, q;
      m = (mass == 0) ? 1 : mass;
      mag = f < 0 ? -f : f;
      q = ((mag * t) << 12) / (m << 16);
      return f < 0 ? -q : q;
    endfunction

    function bit wall_hit(longint x, longint y);
      longint n, l, r, t, b, il, ir, it, ib;
      n = nwalls > 16 ? 16 : nwalls;
      for (int i = 0; i < n; i++) begin
        l = wx0[i] < wx1[i] ? wx0[i] : wx1[i];
        r = wx0[i] < wx1[i] ? wx1[i] : wx0[i];
        t = wy0[i] < wy1[i] ? wy0[i] : wy1[i];
        b = wy0[i] < wy1[i] ? wy1[i] : wy0[i];
        il = (x - radius) > l ? (x - radius) : l;
        ir = (x + radius) < r ? (x + radius) : r;
        it = (y - radius) > t ? (y - radius) : t;
        ib = (y + radius) < b ? (y + radius) : b;
        if (il < ir && it < ib) return 1;
      end
      return 0;
    endfunction

    // Advance the predicted particle for one accepted beat
    function void note_beat(beat_t it);
      state_beat_t e;
      longint t, prev;
      e.bx = 0; e.by = 0;
      case (it.op)
        psb_pkg::CMD_STEP: begin
          t = it.dt > 6554 ? 6554 : it.dt;
          vx = mul_q16(clamp_vel(vx + force_dv(it.fx, t)), friction);
          vy = mul_q16(clamp_vel(vy + force_dv(it.fy, t)), friction);
          prev = px;
          px = px + mul_q16(vx, t);
          if (wall_hit(px, py) || px - radius < 0 || px + radius > width) begin
            px = prev; vx = -mul_q16(vx, bounce); e.bx = 1;
          end
          prev = py;
          py = py + mul_q16(vy, t);
          if (wall_hit(px, py) || py - radius < 0 || py + radius > height) begin
            py = prev; vy = -mul_q16(vy, bounce); e.by = 1;
          end
        end
        psb_pkg::CMD_WALL: begin
          wx0[it.idx] = it.wl; wx1[it.idx] = it.wr;
          wy0[it.idx] = it.wt; wy1[it.idx] = it.wb;
        end
        psb_pkg::CMD_PLACE: center();
        default: ;
      endcase
      e.px = 17'(px); e.py = 17'(py); e.vx = 19'(vx); e.vy = 19'(vy);
      pending_q = {pending_q, e};
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_beat(state_beat_t got);
      state_beat_t e;
      if (pending_q.size() == 0) begin
        report("result beat with nothing expected");
        return;
      end
      e = pending_q.pop_front();
      if (got.px !== e.px) report($sformatf("pos_x %0d exp %0d", got.px, e.px));
      if (got.py !== e.py) report($sformatf("pos_y %0d exp %0d", got.py, e.py));
      if (got.vx !== e.vx) report($sformatf("vel_x %0d exp %0d", got.vx, e.vx));
      if (got.vy !== e.vy) report($sformatf("vel_y %0d exp %0d", got.vy, e.vy));
      if (got.bx !== e.bx) report($sformatf("blocked_x %0b exp %0b", got.bx, e.bx));
      if (got.by !== e.by) report($sformatf("blocked_y %0b exp %0b", got.by, e.by));
    endtask
  endclass

  logic               clk, rst;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid, in_stall;
  logic [1:0]         cmd;
  logic signed [16:0] force_x, force_y;
  logic [15:0]        dt;
  logic [3:0]         wall_index;
  logic signed [16:0] wall_left, wall_top, wall_right, wall_bottom;
  logic               out_valid, out_stall;
  logic signed [16:0] pos_x, pos_y;
  logic signed [18:0] vel_x, vel_y;
  logic               blocked_x, blocked_y;

  particle_scoreboard sb;
  int  burst_left = 0;
  int  beats_sent = 0;
  bit  hold_go = 0;

  particle_step_with_box_collision dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result monitor
  always @(posedge clk) begin
    state_beat_t got;
    if (!rst && out_valid && !out_stall) begin
      got.px = pos_x; got.py = pos_y; got.vx = vel_x; got.vy = vel_y;
      got.bx = blocked_x; got.by = blocked_y;
      sb.check_beat(got);
    end
  end

  // Receiver stall pattern, with one long hold-off
  initial begin
    int mode, cnt;
    bit held;
    out_stall = 0;
    mode = 0; cnt = 0; held = 0;
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        held = 1;
        out_stall <= 1;
        repeat (400) @(negedge clk);
        out_stall <= 0;
      end else begin
        if (cnt == 0) begin
          mode = $urandom_range(0, 3);
          cnt = $urandom_range(20, 150);
        end
        cnt--;
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (cnt % 4 == 0);
        endcase
      end
    end
  end

  // Offer one beat; called and returns at a falling edge
  task automatic send_beat(beat_t it);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    cmd <= it.op; force_x <= it.fx; force_y <= it.fy; dt <= it.dt;
    wall_index <= it.idx; wall_left <= it.wl; wall_top <= it.wt;
    wall_right <= it.wr; wall_bottom <= it.wb;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_beat(it);
    beats_sent++;
    if (beats_sent == 500) hold_go = 1;
    @(negedge clk);
  endtask

  task automatic send_step(int fx, int fy, int t);
    beat_t it;
    it.op = psb_pkg::CMD_STEP; it.fx = 17'(fx); it.fy = 17'(fy); it.dt = 16'(t);
    it.idx = '0; it.wl = '0; it.wt = '0; it.wr = '0; it.wb = '0;
    send_beat(it);
  endtask

  task automatic send_wall(int i, int l, int t, int r, int b);
    beat_t it;
    it.op = psb_pkg::CMD_WALL; it.fx = '0; it.fy = '0; it.dt = '0;
    it.idx = 4'(i); it.wl = 17'(l); it.wt = 17'(t); it.wr = 17'(r); it.wb = 17'(b);
    send_beat(it);
  endtask

  task automatic send_place();
    beat_t it;
    it.op = psb_pkg::CMD_PLACE; it.fx = '0; it.fy = '0; it.dt = '0;
    it.idx = '0; it.wl = '0; it.wt = '0; it.wr = '0; it.wb = '0;
    send_beat(it);
  endtask

  // Register write; leaves cfg_valid high, caller drops it
  task automatic cfg_write(psb_pkg::cfg_idx_t i, logic [15:0] d);
    cfg_index <= i; cfg_data <= d; cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(i, d);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(int m, int r, int w, int h, int f, int b, int n);
    wait_drained();
    cfg_write(psb_pkg::CFG_MASS, 16'(m));
    cfg_write(psb_pkg::CFG_RADIUS, 16'(r));
    cfg_write(psb_pkg::CFG_LIMIT_X, 16'(w));
    cfg_write(psb_pkg::CFG_LIMIT_Y, 16'(h));
    cfg_write(psb_pkg::CFG_FRICTION, 16'(f));
    cfg_write(psb_pkg::CFG_BOUNCE, 16'(b));
    cfg_write(psb_pkg::CFG_WALL_COUNT, 16'(n));
    cfg_valid <= 0;
    send_place();
  endtask

  function automatic int rand_edge(int span);
    if ($urandom_range(0, 9) == 0) return $signed(17'($urandom));
    return $urandom_range(0, span);
  endfunction

  function automatic int rand_force();
    case ($urandom_range(0, 3))
      0: return $signed(17'($urandom));
      1: return $urandom_range(0, 1) ? 65535 : -65536;
      default: return $urandom_range(0, 6000) - 3000;
    endcase
  endfunction

  // Random traffic: mostly steps, with wall rewrites and re-centering
  task automatic random_traffic(int n);
    int sel, a, b, c, d, span;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      span = int'((sb.width > sb.height ? sb.width : sb.height) + 1);
      if (sel < 75) begin
        send_step(rand_force(), rand_force(),
                  $urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 6554));
      end else if (sel < 92) begin
        a = rand_edge(span);
        c = rand_edge(span);
        b = ($urandom_range(0, 19) == 0) ? a : a + $urandom_range(0, 3000);
        d = ($urandom_range(0, 19) == 0) ? c : c + $urandom_range(0, 3000);
        if (b > 65535) b = 65535;
        if (d > 65535) d = 65535;
        // swapped edges now and then
        if ($urandom_range(0, 4) == 0) send_wall($urandom_range(0, 15), b, d, a, c);
        else send_wall($urandom_range(0, 15), a, c, b, d);
      end else begin
        send_place();
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; cmd = 0; force_x = 0; force_y = 0; dt = 0; wall_index = 0;
    wall_left = 0; wall_top = 0; wall_right = 0; wall_bottom = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: fill every wall entry, edge extremes, swapped and empty walls
    send_wall(0, -65536, -65536, -60000, -60000);
    send_wall(15, 65535, 65535, 60000, 60000);
    for (int i = 1; i < 15; i++)
      send_wall(i, 1000 * i, 500, 1000 * i + (i % 3 == 0 ? 0 : 400), 900);
    // Step extremes: forces, zero dt, oversized dt
    send_step(65535, -65536, 6554);
    send_step(-65536, 65535, 65535);
    send_step(0, 0, 0);
    send_step(65535, 65535, 6555);
    send_place();
    send_step(-65536, -65536, 65535);

    // Settings sweep, extremes included
    configure(2560, 320, 32000, 32000, 62915, 32768, 4);
    random_traffic(200);
    configure(1, 0, 65535, 65535, 65535, 65535, 16);
    random_traffic(200);
    configure(65535, 16383, 65535, 65535, 0, 0, 8);
    random_traffic(150);
    configure(300, 100, 0, 0, 40000, 50000, 20);
    random_traffic(100);
    configure($urandom_range(1, 65535), $urandom_range(0, 2000),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 16));
    random_traffic(250);
    configure(1000, 200, 20000, 30000, 65000, 65535, 16);
    random_traffic(300);

    wait_drained();
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Run limit
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
